// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk outside reset.
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_IMPLY(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_IMPLY(lbl, pre, post, msg)
`define ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ===== hdl/scbpa_pkg.sv =====
package scbpa_pkg;

  localparam int DEF_SMALL_BLOCKS  = 64;
  localparam int DEF_MEDIUM_BLOCKS = 32;
  localparam int DEF_LARGE_BLOCKS  = 16;

  localparam logic [31:0] SMALL_BYTES  = 32'd256;
  localparam logic [31:0] MEDIUM_BYTES = 32'd1024;
  localparam logic [31:0] LARGE_BYTES  = 32'd4096;

  localparam logic [6:0] LINK_NIL = 7'd64;

  typedef enum logic {CMD_ALLOC, CMD_FREE} cmd_t;

  typedef enum logic [1:0] {
    CLS_SMALL, CLS_MEDIUM, CLS_LARGE, CLS_NONE
  } size_class_t;

  typedef enum logic [1:0] {
    ST_OK, ST_EMPTY, ST_OVERSIZE, ST_NOT_FOUND
  } status_t;

  typedef struct packed {
    logic       in_use;
    logic [6:0] link;
  } link_entry_t;

  function automatic size_class_t size_to_class(input logic [31:0] size);
    size_class_t cls;
    if (size <= SMALL_BYTES) begin
      cls = CLS_SMALL;
    end else if (size <= MEDIUM_BYTES) begin
      cls = CLS_MEDIUM;
    end else if (size <= LARGE_BYTES) begin
      cls = CLS_LARGE;
    end else begin
      cls = CLS_NONE;
    end
    return cls;
  endfunction

  // Oversize requests report the statistics of the smallest class.
  function automatic logic [1:0] stat_index(input size_class_t cls);
    return (cls == CLS_NONE) ? 2'd0 : 2'(cls);
  endfunction

  function automatic logic [15:0] block_offset(input size_class_t cls,
                                               input logic [5:0] idx);
    logic [15:0] off;
    unique case (cls)
      CLS_SMALL:  off = {2'b00, idx, 8'h00};
      CLS_MEDIUM: off = {idx, 10'h000};
      CLS_LARGE:  off = {idx[3:0], 12'h000};
      CLS_NONE:   off = 16'h0000;
    endcase
    return off;
  endfunction

endpackage

// ===== hdl/size_class_block_pool_allocator.sv =====
// A request and its link memory read are registered when accepted; the result
// is registered once the output is free. The next request is taken only then,
// set by the link memory and free-list head read-modify-write it depends on.
// Reset: synchronous; list heads, free counts and statistics are set at once,
// and per-class fill counts stand in for the initial chains, so no clearing pass.
`include "assert_macros.svh"

module size_class_block_pool_allocator
  import scbpa_pkg::*;
#(
  parameter int SMALL_BLOCKS  = DEF_SMALL_BLOCKS,
  parameter int MEDIUM_BLOCKS = DEF_MEDIUM_BLOCKS,
  parameter int LARGE_BLOCKS  = DEF_LARGE_BLOCKS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [31:0] request_size,
  input  logic [5:0]  block_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [1:0]  size_class,
  output logic [5:0]  granted_index,
  output logic [15:0] byte_offset,
  output logic [6:0]  blocks_free,
  output logic [6:0]  peak_in_use,
  output logic [31:0] alloc_total,
  output logic [31:0] free_total,
  output logic [31:0] miss_total
);

  localparam int TOTAL  = SMALL_BLOCKS + MEDIUM_BLOCKS + LARGE_BLOCKS;
  localparam int ADDR_W = $clog2(TOTAL);

  localparam logic [6:0] CLS_CNT [3] = '{
    7'(SMALL_BLOCKS), 7'(MEDIUM_BLOCKS), 7'(LARGE_BLOCKS)
  };
  localparam logic [ADDR_W-1:0] CLS_BASE [3] = '{
    ADDR_W'(0), ADDR_W'(SMALL_BLOCKS), ADDR_W'(SMALL_BLOCKS + MEDIUM_BLOCKS)
  };

  logic [6:0]  list_head     [3];
  logic [6:0]  free_left     [3];
  logic [6:0]  peak_used     [3];
  logic [6:0]  fill          [3];
  logic [31:0] alloc_counter [3];
  logic [31:0] free_counter  [3];
  logic [31:0] miss_counter  [3];

  logic [6:0]  list_head_next     [3];
  logic [6:0]  free_left_next     [3];
  logic [6:0]  peak_used_next     [3];
  logic [6:0]  fill_next          [3];
  logic [31:0] alloc_counter_next [3];
  logic [31:0] free_counter_next  [3];
  logic [31:0] miss_counter_next  [3];

  logic        busy;
  cmd_t        cmd_q;
  size_class_t cls_q;
  logic [6:0]  idx_q;

  size_class_t      in_cls;
  logic [1:0]       in_c;
  logic [6:0]       in_idx;
  logic             accept;
  logic             rd_en;
  logic [ADDR_W-1:0] rd_addr;
  link_entry_t      rd_data;

  logic             proc;
  logic [1:0]       c;
  logic             untouched;
  logic             idx_ok;
  logic             eff_use;
  logic [6:0]       eff_link;
  logic [6:0]       used;
  logic             wr_req;
  logic [ADDR_W-1:0] wr_addr;
  link_entry_t      wr_data;
  status_t          res_status;
  logic [5:0]       res_idx;

  // Request side: decode the class and start the link memory read.
  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign in_cls   = size_to_class(request_size);
  assign in_c     = stat_index(in_cls);
  assign in_idx   = (cmd_t'(cmd) == CMD_FREE) ? {1'b0, block_index} : list_head[in_c];
  assign rd_en    = accept && (in_cls != CLS_NONE) && (in_idx < CLS_CNT[in_c]);
  assign rd_addr  = CLS_BASE[in_c] + ADDR_W'(in_idx);

  scbpa_link_mem #(
    .DEPTH (TOTAL)
  ) u_link_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (proc && wr_req),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Blocks at or above the fill count were never popped, so their memory entry
  // is ignored and their reset chain entry is used instead.
  assign proc      = busy && (!out_valid || out_ready);
  assign c         = stat_index(cls_q);
  assign untouched = idx_q >= fill[c];
  assign idx_ok    = idx_q < CLS_CNT[c];
  assign eff_use   = untouched ? 1'b0 : rd_data.in_use;
  assign eff_link  = !untouched ? rd_data.link :
                     ((idx_q + 7'd1) < CLS_CNT[c]) ? (idx_q + 7'd1) : LINK_NIL;
  assign wr_addr   = CLS_BASE[c] + ADDR_W'(idx_q);

  always_comb begin
    list_head_next     = list_head;
    free_left_next     = free_left;
    peak_used_next     = peak_used;
    fill_next          = fill;
    alloc_counter_next = alloc_counter;
    free_counter_next  = free_counter;
    miss_counter_next  = miss_counter;
    wr_req             = 1'b0;
    wr_data            = '{in_use: 1'b0, link: LINK_NIL};
    res_status         = ST_OK;
    res_idx            = 6'd0;
    used               = 7'd0;
    if (cls_q == CLS_NONE) begin
      res_status = ST_OVERSIZE;
      if (cmd_q == CMD_ALLOC) begin
        miss_counter_next[0] = miss_counter[0] + 32'd1;
      end
    end else if (cmd_q == CMD_ALLOC) begin
      if (!idx_ok) begin
        res_status           = ST_EMPTY;
        miss_counter_next[c] = miss_counter[c] + 32'd1;
      end else begin
        res_idx           = idx_q[5:0];
        wr_req            = 1'b1;
        wr_data           = '{in_use: 1'b1, link: eff_link};
        list_head_next[c] = eff_link;
        if (untouched) begin
          fill_next[c] = idx_q + 7'd1;
        end
        if (free_left[c] != 7'd0) begin
          free_left_next[c] = free_left[c] - 7'd1;
        end
        alloc_counter_next[c] = alloc_counter[c] + 32'd1;
        used = CLS_CNT[c] - free_left_next[c];
        if (used > peak_used[c]) begin
          peak_used_next[c] = used;
        end
      end
    end else begin
      if (!idx_ok || !eff_use) begin
        res_status = ST_NOT_FOUND;
      end else begin
        res_idx           = idx_q[5:0];
        wr_req            = 1'b1;
        wr_data           = '{in_use: 1'b0, link: list_head[c]};
        list_head_next[c] = idx_q;
        if (free_left[c] < CLS_CNT[c]) begin
          free_left_next[c] = free_left[c] + 7'd1;
        end
        free_counter_next[c] = free_counter[c] + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        list_head[k]     <= 7'd0;
        free_left[k]     <= CLS_CNT[k];
        peak_used[k]     <= 7'd0;
        fill[k]          <= 7'd0;
        alloc_counter[k] <= 32'd0;
        free_counter[k]  <= 32'd0;
        miss_counter[k]  <= 32'd0;
      end
    end else begin
      if (proc) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        busy  <= 1'b1;
        cmd_q <= cmd_t'(cmd);
        cls_q <= in_cls;
        idx_q <= in_idx;
      end
      if (proc) begin
        busy          <= 1'b0;
        list_head     <= list_head_next;
        free_left     <= free_left_next;
        peak_used     <= peak_used_next;
        fill          <= fill_next;
        alloc_counter <= alloc_counter_next;
        free_counter  <= free_counter_next;
        miss_counter  <= miss_counter_next;
        status        <= res_status;
        size_class    <= cls_q;
        granted_index <= res_idx;
        byte_offset   <= (res_status == ST_OK) ? block_offset(cls_q, res_idx) : 16'h0000;
        blocks_free   <= free_left_next[c];
        peak_in_use   <= peak_used_next[c];
        alloc_total   <= alloc_counter_next[c];
        free_total    <= free_counter_next[c];
        miss_total    <= miss_counter_next[c];
      end
    end
  end

  `ASSERT_NEXT(a_accept_busy, accept, busy && !in_ready, "request accepted without going busy")
  `ASSERT_IMPLY(a_ok_has_class, out_valid && status == ST_OK, size_class != CLS_NONE, "ok result without a class")
  `ASSERT_IMPLY(a_refused_zero, out_valid && status != ST_OK, granted_index == 6'd0 && byte_offset == 16'h0000, "refused result carries an index")

  for (genvar g = 0; g < 3; g++) begin : g_cls_chk
    `ASSERT_ALWAYS(a_peak_covers_used, ({1'b0, peak_used[g]} + {1'b0, free_left[g]}) >= {1'b0, CLS_CNT[g]}, "peak below blocks in use")
    `ASSERT_ALWAYS(a_untouched_free, free_left[g] >= (CLS_CNT[g] - fill[g]), "unpopped blocks not counted free")
  end

endmodule

// ===== hdl/scbpa_link_mem.sv =====
module scbpa_link_mem
  import scbpa_pkg::*;
#(
  parameter int DEPTH = DEF_SMALL_BLOCKS + DEF_MEDIUM_BLOCKS + DEF_LARGE_BLOCKS
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output link_entry_t              rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  link_entry_t              wr_data
);

  link_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== dv/size_class_block_pool_allocator_test.sv =====
module size_class_block_pool_allocator_test;
  import scbpa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CLASSES = 3;
  localparam int NUM_BLOCKS = DEF_SMALL_BLOCKS + DEF_MEDIUM_BLOCKS + DEF_LARGE_BLOCKS;

  typedef struct packed {
    status_t     status;
    size_class_t size_class;
    logic [5:0]  granted_index;
    logic [15:0] byte_offset;
    logic [6:0]  blocks_free;
    logic [6:0]  peak_in_use;
    logic [31:0] alloc_total;
    logic [31:0] free_total;
    logic [31:0] miss_total;
  } pool_result_t;

  class pool_checker;
    int          blocks [NUM_CLASSES];
    int          base [NUM_CLASSES];
    int          shift [NUM_CLASSES];
    logic [6:0]  link_next [NUM_BLOCKS];
    bit          in_use [NUM_BLOCKS];
    logic [6:0]  head [NUM_CLASSES];
    logic [6:0]  free_left [NUM_CLASSES];
    logic [6:0]  peak [NUM_CLASSES];
    logic [31:0] allocs [NUM_CLASSES];
    logic [31:0] frees [NUM_CLASSES];
    logic [31:0] misses [NUM_CLASSES];
    pool_result_t expected_results [$];
    int          failures;

    function new();
      blocks = '{DEF_SMALL_BLOCKS, DEF_MEDIUM_BLOCKS, DEF_LARGE_BLOCKS};
      base = '{0, DEF_SMALL_BLOCKS, DEF_SMALL_BLOCKS + DEF_MEDIUM_BLOCKS};
      shift = '{8, 10, 12};
      failures = 0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        for (int i = 0; i < blocks[c]; i++) begin
          link_next[base[c] + i] = (i + 1 < blocks[c]) ? 7'(i + 1) : LINK_NIL;
          in_use[base[c] + i] = 1'b0;
        end
        head[c] = 7'd0;
        free_left[c] = 7'(blocks[c]);
        peak[c] = 7'd0;
        allocs[c] = 32'd0;
        frees[c] = 32'd0;
        misses[c] = 32'd0;
      end
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    function bit pick_in_use(int c, output logic [5:0] idx);
      int hits [$];
      for (int i = 0; i < blocks[c]; i++) begin
        if (in_use[base[c] + i]) hits.push_back(i);
      end
      idx = 6'd0;
      if (hits.size() == 0) return 1'b0;
      idx = 6'(hits[$urandom_range(hits.size() - 1)]);
      return 1'b1;
    endfunction

    function void note_request(cmd_t op, logic [31:0] req_size, logic [5:0] idx);
      pool_result_t r;
      int c;
      int stat_c;
      int slot;
      logic [6:0] used;
      r = '0;
      if (req_size <= SMALL_BYTES) c = 0;
      else if (req_size <= MEDIUM_BYTES) c = 1;
      else if (req_size <= LARGE_BYTES) c = 2;
      else c = 3;
      stat_c = (c == 3) ? 0 : c;
      if (c == 3) begin
        if (op == CMD_ALLOC) misses[0]++;
        r.status = ST_OVERSIZE;
        r.size_class = CLS_NONE;
      end else if (op == CMD_ALLOC) begin
        r.size_class = size_class_t'(c);
        if (head[c] >= LINK_NIL || int'(head[c]) >= blocks[c]) begin
          misses[c]++;
          r.status = ST_EMPTY;
        end else begin
          slot = base[c] + int'(head[c]);
          r.status = ST_OK;
          r.granted_index = head[c][5:0];
          r.byte_offset = 16'(32'(head[c]) << shift[c]);
          head[c] = link_next[slot];
          in_use[slot] = 1'b1;
          if (free_left[c] > 0) free_left[c]--;
          allocs[c]++;
          used = 7'(blocks[c]) - free_left[c];
          if (used > peak[c]) peak[c] = used;
        end
      end else begin
        r.size_class = size_class_t'(c);
        slot = base[c] + int'(idx);
        if (int'(idx) >= blocks[c] || !in_use[slot]) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.status = ST_OK;
          r.granted_index = idx;
          r.byte_offset = 16'(32'(idx) << shift[c]);
          link_next[slot] = head[c];
          head[c] = {1'b0, idx};
          in_use[slot] = 1'b0;
          if (int'(free_left[c]) < blocks[c]) free_left[c]++;
          frees[c]++;
        end
      end
      r.blocks_free = free_left[stat_c];
      r.peak_in_use = peak[stat_c];
      r.alloc_total = allocs[stat_c];
      r.free_total = frees[stat_c];
      r.miss_total = misses[stat_c];
      expected_results.push_back(r);
    endfunction

    function void spread(pool_result_t r, output logic [31:0] v [9]);
      v[0] = 32'(r.status);
      v[1] = 32'(r.size_class);
      v[2] = 32'(r.granted_index);
      v[3] = 32'(r.byte_offset);
      v[4] = 32'(r.blocks_free);
      v[5] = 32'(r.peak_in_use);
      v[6] = r.alloc_total;
      v[7] = r.free_total;
      v[8] = r.miss_total;
    endfunction

    function void check_result(pool_result_t got);
      pool_result_t want;
      logic [31:0] want_v [9];
      logic [31:0] got_v [9];
      string tag [9];
      if (expected_results.size() == 0) begin
        report($sformatf("result beat with nothing expected, status %0d", got.status));
        return;
      end
      want = expected_results.pop_front();
      tag = '{"status", "size_class", "granted_index", "byte_offset", "blocks_free",
              "peak_in_use", "alloc_total", "free_total", "miss_total"};
      spread(want, want_v);
      spread(got, got_v);
      for (int i = 0; i < 9; i++) begin
        if (want_v[i] !== got_v[i]) begin
          report($sformatf("%s mismatch: expected %0h, got %0h", tag[i], want_v[i], got_v[i]));
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = 1'b0;
  logic [31:0] request_size = 32'd0;
  logic [5:0]  block_index = 6'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [1:0]  size_class;
  logic [5:0]  granted_index;
  logic [15:0] byte_offset;
  logic [6:0]  blocks_free;
  logic [6:0]  peak_in_use;
  logic [31:0] alloc_total;
  logic [31:0] free_total;
  logic [31:0] miss_total;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;

  pool_checker sb = new();

  size_class_block_pool_allocator i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .request_size (request_size),
    .block_index  (block_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .size_class   (size_class),
    .granted_index(granted_index),
    .byte_offset  (byte_offset),
    .blocks_free  (blocks_free),
    .peak_in_use  (peak_in_use),
    .alloc_total  (alloc_total),
    .free_total   (free_total),
    .miss_total   (miss_total)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    pool_result_t got;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got.status = status_t'(status);
        got.size_class = size_class_t'(size_class);
        got.granted_index = granted_index;
        got.byte_offset = byte_offset;
        got.blocks_free = blocks_free;
        got.peak_in_use = peak_in_use;
        got.alloc_total = alloc_total;
        got.free_total = free_total;
        got.miss_total = miss_total;
        sb.check_result(got);
      end
      if (hold_off_cycles > 0) begin
        out_ready <= 1'b0;
        hold_off_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_request(cmd_t op, logic [31:0] req_size, logic [5:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    request_size <= req_size;
    block_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(op, req_size, idx);
  endtask

  task automatic drain(int limit);
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (sb.outstanding() != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
  endtask

  function automatic logic [31:0] size_in_class(int c);
    case (c)
      0: return $urandom_range(SMALL_BYTES, 0);
      1: return $urandom_range(MEDIUM_BYTES, SMALL_BYTES + 1);
      2: return $urandom_range(LARGE_BYTES, MEDIUM_BYTES + 1);
      default: return $urandom_range(32'hFFFF_FFFF, LARGE_BYTES + 1);
    endcase
  endfunction

  task automatic run_phase(int idle_pct, int stall_pct, int items, bit hold_off);
    int done;
    int burst;
    int alloc_pct;
    int pick;
    int c;
    logic [5:0] idx;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    if (hold_off) hold_off_cycles = 300;
    done = 0;
    while (done < items) begin
      burst = $urandom_range(80, 10);
      if (burst > items - done) burst = items - done;
      alloc_pct = ($urandom_range(1) == 1) ? 80 : 30;
      repeat (burst) begin
        pick = $urandom_range(99);
        c = $urandom_range(3);
        if (c == 3) c = 0;
        if (pick < 4) begin
          send_request(cmd_t'($urandom_range(1)), size_in_class(3), 6'($urandom_range(63)));
        end else if (pick < 12) begin
          send_request(CMD_FREE, size_in_class(c), 6'($urandom_range(63)));
        end else if (pick < alloc_pct) begin
          send_request(CMD_ALLOC, size_in_class(c), 6'($urandom_range(63)));
        end else begin
          if (!sb.pick_in_use(c, idx)) idx = 6'($urandom_range(63));
          send_request(CMD_FREE, size_in_class(c), idx);
        end
        done++;
      end
    end
    drain(20000);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_request(CMD_ALLOC, 32'd0, 6'd0);
    send_request(CMD_ALLOC, SMALL_BYTES, 6'd63);
    send_request(CMD_ALLOC, SMALL_BYTES + 1, 6'd0);
    send_request(CMD_ALLOC, MEDIUM_BYTES, 6'd0);
    send_request(CMD_ALLOC, MEDIUM_BYTES + 1, 6'd0);
    send_request(CMD_ALLOC, LARGE_BYTES, 6'd0);
    send_request(CMD_ALLOC, LARGE_BYTES + 1, 6'd0);
    send_request(CMD_ALLOC, 32'hFFFF_FFFF, 6'd63);
    send_request(CMD_FREE, 32'hFFFF_FFFF, 6'd63);
    send_request(CMD_FREE, SMALL_BYTES, 6'd1);
    send_request(CMD_FREE, SMALL_BYTES, 6'd1);
    send_request(CMD_FREE, MEDIUM_BYTES, 6'd63);
    send_request(CMD_FREE, LARGE_BYTES, 6'd20);
    send_request(CMD_ALLOC, 32'd1, 6'd0);
    repeat (DEF_LARGE_BLOCKS - 1) send_request(CMD_ALLOC, LARGE_BYTES, 6'd0);
    drain(20000);

    run_phase(0, 0, 320, 1'b1);
    run_phase(76, 0, 320, 1'b0);
    run_phase(0, 76, 320, 1'b0);
    run_phase(31, 31, 320, 1'b0);

    if (sb.outstanding() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.outstanding()));
    end
    if (sb.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/scbpa_pkg.sv
hdl/scbpa_link_mem.sv
hdl/size_class_block_pool_allocator.sv
dv/size_class_block_pool_allocator_test.sv
